### hw/rtl/huffman_tree_walk_decoder_defines.svh
// Assertion macros for the Huffman tree-walk decoder.
// Included by RTL files that carry concurrent assertions; no other dependencies.
`ifndef HUFFMAN_TREE_WALK_DECODER_DEFINES_SVH
`define HUFFMAN_TREE_WALK_DECODER_DEFINES_SVH
`ifndef SYNTHESIS
`define HTWD_ASSERT_NOW(lbl, clk, rst_n, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
		else $error(msg);
`define HTWD_ASSERT_NEXT(lbl, clk, rst_n, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
		else $error(msg);
`else
`define HTWD_ASSERT_NOW(lbl, clk, rst_n, ante, cons, msg)
`define HTWD_ASSERT_NEXT(lbl, clk, rst_n, ante, cons, msg)
`endif
`endif

### hw/rtl/htwd_pkg.sv
// Shared constants, node and control types for the Huffman tree-walk decoder.
// No dependencies.
`default_nettype none
package htwd_pkg;

	localparam int MAX_NODES = 512;
	localparam int NODE_AW   = (MAX_NODES > 1) ? $clog2(MAX_NODES) : 1;
	localparam int IDX_W     = 9;
	localparam int SYM_W     = 9;
	localparam int BYTE_W    = 8;
	localparam int OUT_SYM_W = 8;
	localparam int CNT_W     = $clog2(BYTE_W + 1);

	localparam int CFG_IDX_W  = 1;
	localparam int CFG_DATA_W = 9;
	localparam logic [CFG_IDX_W-1:0] REG_ROOT_INDEX = 1'd0;
	localparam logic [CFG_IDX_W-1:0] REG_EOF_SYMBOL = 1'd1;

	typedef logic [IDX_W-1:0] idx_t;
	typedef logic [SYM_W-1:0] sym_t;

	localparam idx_t ROOT_RESET = 9'd0;
	localparam sym_t EOF_RESET  = 9'd256;

	typedef struct packed {
		logic leaf;
		sym_t symbol;
		idx_t zero;
		idx_t one;
	} node_t;

	localparam int NODE_W = $bits(node_t);

	typedef logic [1:0] rd_sel_t;
	localparam rd_sel_t RD_NONE  = 2'd0;
	localparam rd_sel_t RD_WALK  = 2'd1;
	localparam rd_sel_t RD_CHILD = 2'd2;
	localparam rd_sel_t RD_ROOT  = 2'd3;

	typedef struct packed {
		logic    node_wr;
		logic    clr_ended;
		logic    set_ended;
		logic    byte_load;
		rd_sel_t rd_sel;
		logic    walk_root;
		logic    push;
		logic    push_last;
		logic    pend_new;
		logic    pend_clr;
	} cmd_t;

	typedef struct packed {
		logic ended;
		logic leaf;
		logic eof;
		logic cnt_zero;
		logic pend_valid;
		logic out_free;
	} sts_t;

	function automatic logic node_in_range(input idx_t idx);
		return int'(idx) < MAX_NODES;
	endfunction

	function automatic logic [NODE_AW-1:0] node_ram_addr(input idx_t idx);
		return NODE_AW'(idx);
	endfunction

endpackage
`default_nettype wire

### hw/rtl/htwd_ram.sv
// Generic single-port-write, single-port-read RAM with registered read data.
// No dependencies.
`default_nettype none
module htwd_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 16
) (
	input  wire logic                                   clk,
	input  wire logic                                   we,
	input  wire logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] waddr,
	input  wire logic [WIDTH-1:0]                       wdata,
	input  wire logic                                   re,
	input  wire logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] raddr,
	output logic      [WIDTH-1:0]                       rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		if (re) begin
			rdata <= mem_q[raddr];
		end
	end

endmodule
`default_nettype wire

### hw/rtl/htwd_datapath.sv
// Datapath: node table, walk position, bit shifter, pending result and output register.
// Depends on htwd_pkg and htwd_ram.
`default_nettype none
module htwd_datapath (
	input  wire logic                          clk,
	input  wire logic                          arst_n,
	input  wire htwd_pkg::cmd_t                cmd,
	output htwd_pkg::sts_t                     sts,
	input  wire logic [8:0]                    node_addr,
	input  wire logic                          node_leaf,
	input  wire logic [8:0]                    node_symbol,
	input  wire logic [8:0]                    node_zero,
	input  wire logic [8:0]                    node_one,
	input  wire logic [7:0]                    data_byte,
	input  wire logic                          cfg_wr_en,
	input  wire logic [htwd_pkg::CFG_IDX_W-1:0]  cfg_index,
	input  wire logic [htwd_pkg::CFG_DATA_W-1:0] cfg_wdata,
	input  wire logic                          out_ready,
	output logic                               out_valid,
	output logic      [7:0]                    out_symbol,
	output logic                               out_end,
	output logic                               out_last
);

	import htwd_pkg::*;

	idx_t                 root_q;
	sym_t                 eof_q;
	idx_t                 walk_q;
	logic                 ended_q;
	logic [BYTE_W-1:0]    byte_q;
	logic [CNT_W-1:0]     cnt_q;
	logic                 pend_valid_q;
	logic [OUT_SYM_W-1:0] pend_sym_q;
	logic                 pend_end_q;
	logic                 out_valid_q;
	logic [OUT_SYM_W-1:0] out_symbol_q;
	logic                 out_end_q;
	logic                 out_last_q;
	logic                 rd_range_q;

	logic [NODE_W-1:0] rdata;
	node_t             cur_node;
	idx_t              child_idx;
	idx_t              rd_idx;
	logic              rd_en;
	logic              wr_en;
	node_t             wr_node;
	logic              out_free;

	assign cur_node  = rd_range_q ? node_t'(rdata) : '0;
	assign child_idx = byte_q[BYTE_W-1] ? cur_node.one : cur_node.zero;

	always_comb begin
		case (cmd.rd_sel)
			RD_CHILD: rd_idx = child_idx;
			RD_ROOT:  rd_idx = root_q;
			default:  rd_idx = walk_q;
		endcase
	end

	assign rd_en   = cmd.rd_sel != RD_NONE;
	assign wr_en   = cmd.node_wr && node_in_range(node_addr);
	assign wr_node = '{leaf: node_leaf, symbol: node_symbol, zero: node_zero, one: node_one};

	htwd_ram #(
		.WIDTH(NODE_W),
		.DEPTH(MAX_NODES)
	) u_node_ram (
		.clk  (clk),
		.we   (wr_en),
		.waddr(node_ram_addr(node_addr)),
		.wdata(wr_node),
		.re   (rd_en),
		.raddr(node_ram_addr(rd_idx)),
		.rdata(rdata)
	);

	always_ff @(posedge clk) begin
		if (rd_en) begin
			rd_range_q <= node_in_range(rd_idx);
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			root_q <= ROOT_RESET;
			eof_q  <= EOF_RESET;
		end else if (cfg_wr_en) begin
			unique case (cfg_index)
				REG_ROOT_INDEX: root_q <= cfg_wdata[IDX_W-1:0];
				REG_EOF_SYMBOL: eof_q  <= cfg_wdata[SYM_W-1:0];
				default: ;
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			walk_q  <= ROOT_RESET;
			ended_q <= 1'b0;
			cnt_q   <= '0;
		end else begin
			if (cmd.rd_sel == RD_CHILD) begin
				walk_q <= child_idx;
			end else if (cmd.walk_root) begin
				walk_q <= root_q;
			end
			if (cmd.clr_ended) begin
				ended_q <= 1'b0;
			end else if (cmd.set_ended) begin
				ended_q <= 1'b1;
			end
			if (cmd.byte_load) begin
				cnt_q <= CNT_W'(BYTE_W);
			end else if (cmd.rd_sel == RD_CHILD) begin
				cnt_q <= cnt_q - CNT_W'(1);
			end
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.byte_load) begin
			byte_q <= data_byte;
		end else if (cmd.rd_sel == RD_CHILD) begin
			byte_q <= {byte_q[BYTE_W-2:0], 1'b0};
		end
	end

	// pending result: held until we know whether it is the byte's last
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pend_valid_q <= 1'b0;
		end else if (cmd.pend_new) begin
			pend_valid_q <= 1'b1;
		end else if (cmd.pend_clr) begin
			pend_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.pend_new) begin
			pend_end_q <= sts.eof;
			pend_sym_q <= sts.eof ? '0 : cur_node.symbol[OUT_SYM_W-1:0];
		end
	end

	assign out_free = !out_valid_q || out_ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (cmd.push) begin
			out_valid_q <= 1'b1;
		end else if (out_ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.push) begin
			out_symbol_q <= pend_sym_q;
			out_end_q    <= pend_end_q;
			out_last_q   <= cmd.push_last;
		end
	end

	assign sts.ended      = ended_q;
	assign sts.leaf       = cur_node.leaf;
	assign sts.eof        = cur_node.symbol == eof_q;
	assign sts.cnt_zero   = cnt_q == '0;
	assign sts.pend_valid = pend_valid_q;
	assign sts.out_free   = out_free;

	assign out_valid  = out_valid_q;
	assign out_symbol = out_symbol_q;
	assign out_end    = out_end_q;
	assign out_last   = out_last_q;

endmodule
`default_nettype wire

### hw/rtl/htwd_ctrl.sv
// Controller FSM: sequences request intake, one tree step per bit and result flush.
// Depends on htwd_pkg.
`default_nettype none
module htwd_ctrl (
	input  wire logic           clk,
	input  wire logic           arst_n,
	input  wire logic           in_valid,
	input  wire logic           req_type,
	output logic                in_ready,
	input  wire htwd_pkg::sts_t sts,
	output htwd_pkg::cmd_t      cmd
);

	import htwd_pkg::*;

	localparam logic [1:0] S_IDLE  = 2'd0;
	localparam logic [1:0] S_STEP  = 2'd1;
	localparam logic [1:0] S_TEST  = 2'd2;
	localparam logic [1:0] S_FLUSH = 2'd3;

	logic [1:0] state_q;
	logic [1:0] state_d;

	assign in_ready = state_q == S_IDLE;

	always_comb begin
		cmd     = '0;
		state_d = state_q;
		unique case (state_q)
			S_IDLE: begin
				if (in_valid) begin
					if (!req_type) begin
						cmd.node_wr   = 1'b1;
						cmd.walk_root = 1'b1;
						cmd.clr_ended = 1'b1;
					end else if (!sts.ended) begin
						cmd.byte_load = 1'b1;
						cmd.rd_sel    = RD_WALK;
						state_d       = S_STEP;
					end
				end
			end
			S_STEP: begin
				cmd.rd_sel = RD_CHILD;
				state_d    = S_TEST;
			end
			S_TEST: begin
				if (sts.leaf) begin
					if (!sts.pend_valid || sts.out_free) begin
						cmd.push      = sts.pend_valid;
						cmd.pend_new  = 1'b1;
						cmd.walk_root = 1'b1;
						if (sts.eof) begin
							cmd.set_ended = 1'b1;
							state_d       = S_FLUSH;
						end else if (sts.cnt_zero) begin
							state_d = S_FLUSH;
						end else begin
							cmd.rd_sel = RD_ROOT;
							state_d    = S_STEP;
						end
					end
				end else if (sts.cnt_zero) begin
					state_d = S_FLUSH;
				end else begin
					cmd.rd_sel = RD_CHILD;
				end
			end
			S_FLUSH: begin
				if (!sts.pend_valid) begin
					state_d = S_IDLE;
				end else if (sts.out_free) begin
					cmd.push      = 1'b1;
					cmd.push_last = 1'b1;
					cmd.pend_clr  = 1'b1;
					state_d       = S_IDLE;
				end
			end
			default: state_d = S_IDLE;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

endmodule
`default_nettype wire

### hw/rtl/huffman_tree_walk_decoder.sv
// Top level of the Huffman tree-walk decoder: controller plus datapath.
// Depends on htwd_pkg, htwd_ctrl, htwd_datapath and the defines header.
`default_nettype none
`include "huffman_tree_walk_decoder_defines.svh"
// A load request (req_type 0) writes one node of the code tree, moves the walk back to
// the root and clears the end mark. A data request (req_type 1) walks the tree one bit
// per cycle, MSB first, through the node RAM's registered read port, except that each
// leaf reached before the byte's final bit costs one root re-read and the walk waits
// while the output is held off. The last symbol of a byte is kept one step so out_last
// can be set on it. After the end symbol, data requests are taken and dropped until the
// next load. Node entries must be loaded before the walk reads them; there is no
// clearing pass after reset.
module huffman_tree_walk_decoder (
	input  wire logic                            clk,
	input  wire logic                            arst_n,
	input  wire logic                            in_valid,
	output logic                                 in_ready,
	input  wire logic                            req_type,
	input  wire logic [8:0]                      node_addr,
	input  wire logic                            node_leaf,
	input  wire logic [8:0]                      node_symbol,
	input  wire logic [8:0]                      node_zero,
	input  wire logic [8:0]                      node_one,
	input  wire logic [7:0]                      data_byte,
	output logic                                 out_valid,
	input  wire logic                            out_ready,
	output logic      [7:0]                      out_symbol,
	output logic                                 out_end,
	output logic                                 out_last,
	input  wire logic                            cfg_wr_en,
	input  wire logic [htwd_pkg::CFG_IDX_W-1:0]  cfg_index,
	input  wire logic [htwd_pkg::CFG_DATA_W-1:0] cfg_wdata
);

	import htwd_pkg::*;

	cmd_t cmd;
	sts_t sts;

	htwd_ctrl u_ctrl (
		.clk     (clk),
		.arst_n  (arst_n),
		.in_valid(in_valid),
		.req_type(req_type),
		.in_ready(in_ready),
		.sts     (sts),
		.cmd     (cmd)
	);

	htwd_datapath u_datapath (
		.clk        (clk),
		.arst_n     (arst_n),
		.cmd        (cmd),
		.sts        (sts),
		.node_addr  (node_addr),
		.node_leaf  (node_leaf),
		.node_symbol(node_symbol),
		.node_zero  (node_zero),
		.node_one   (node_one),
		.data_byte  (data_byte),
		.cfg_wr_en  (cfg_wr_en),
		.cfg_index  (cfg_index),
		.cfg_wdata  (cfg_wdata),
		.out_ready  (out_ready),
		.out_valid  (out_valid),
		.out_symbol (out_symbol),
		.out_end    (out_end),
		.out_last   (out_last)
	);

	`HTWD_ASSERT_NOW(a_push_room, clk, arst_n, cmd.push, sts.out_free && sts.pend_valid, "result pushed into a full output register or from an empty pending slot")
	`HTWD_ASSERT_NOW(a_wr_on_load, clk, arst_n, cmd.node_wr, in_valid && in_ready && !req_type, "node write without an accepted load request")
	`HTWD_ASSERT_NEXT(a_busy_after_read, clk, arst_n, cmd.rd_sel != RD_NONE, !in_ready, "input ready while a table read is in flight")

endmodule
`default_nettype wire

### tb/tb_huffman_tree_walk_decoder.sv
// Self-checking bench for huffman_tree_walk_decoder: directed and random tree loads and
// coded bytes with random handshake gaps, checked against an in-bench tree-walk predictor.
// Depends on htwd_pkg and the decoder RTL only.
module tb_huffman_tree_walk_decoder;
	import htwd_pkg::*;

	localparam logic REQ_LOAD = 1'b0;
	localparam logic REQ_DATA = 1'b1;
	localparam int DRAIN_CYCLES = 40;
	localparam int STALL_LIMIT = 1500;

	typedef struct packed {
		logic       kind;
		idx_t       addr;
		logic       leaf;
		sym_t       sym;
		idx_t       zero;
		idx_t       one;
		logic [7:0] data_val;
	} req_t;

	typedef struct packed {
		logic [7:0] sym;
		logic       fin;
		logic       last;
	} decoded_t;

	logic clk, arst_n;
	logic in_valid, in_ready, req_type, node_leaf;
	logic [8:0] node_addr, node_symbol, node_zero, node_one;
	logic [7:0] data_byte;
	logic out_valid, out_ready, out_end, out_last;
	logic [7:0] out_symbol;
	logic cfg_wr_en;
	logic [CFG_IDX_W-1:0] cfg_index;
	logic [CFG_DATA_W-1:0] cfg_wdata;

	huffman_tree_walk_decoder dut (
		.clk(clk), .arst_n(arst_n),
		.in_valid(in_valid), .in_ready(in_ready), .req_type(req_type),
		.node_addr(node_addr), .node_leaf(node_leaf), .node_symbol(node_symbol),
		.node_zero(node_zero), .node_one(node_one), .data_byte(data_byte),
		.out_valid(out_valid), .out_ready(out_ready), .out_symbol(out_symbol),
		.out_end(out_end), .out_last(out_last),
		.cfg_wr_en(cfg_wr_en), .cfg_index(cfg_index), .cfg_wdata(cfg_wdata)
	);

	// predictor state
	node_t tree_mem [MAX_NODES];
	idx_t walk_pos, root_reg;
	sym_t eof_reg;
	bit stream_done;
	decoded_t decoded_due[$];

	// generator view, keeps every walk on written nodes
	bit gen_written [MAX_NODES];
	bit gen_inner [MAX_NODES];
	int gen_wlist[$];
	idx_t gen_root;
	sym_t gen_eof;

	req_t req_backlog[$];
	req_t cur_req;
	int pushed_count, taken_count, err_count, stall_count;
	int burst_left, gap_left, pat_age;
	bit req_taken, moved;
	logic [15:0] ready_pat;
	decoded_t want;

	initial begin
		clk = 1'b0;
		forever #6 clk = ~clk;
	end

	function automatic void predict_symbols(req_t r);
		decoded_t found[$];
		node_t cur, nxt;
		int b;
		if (r.kind == REQ_LOAD) begin
			tree_mem[r.addr] = '{leaf: r.leaf, symbol: r.sym, zero: r.zero, one: r.one};
			walk_pos = root_reg;
			stream_done = 1'b0;
			return;
		end
		if (stream_done)
			return;
		for (b = 7; b >= 0; b--) begin
			cur = tree_mem[walk_pos];
			walk_pos = r.data_val[b] ? cur.one : cur.zero;
			nxt = tree_mem[walk_pos];
			if (!nxt.leaf)
				continue;
			walk_pos = root_reg;
			if (nxt.symbol == eof_reg) begin
				found.insert(found.size(), decoded_t'{sym: 8'd0, fin: 1'b1, last: 1'b0});
				stream_done = 1'b1;
				break;
			end
			found.insert(found.size(),
				decoded_t'{sym: nxt.symbol[7:0], fin: 1'b0, last: 1'b0});
		end
		if (found.size() > 0)
			found[found.size()-1].last = 1'b1;
		foreach (found[i])
			decoded_due.insert(decoded_due.size(), found[i]);
	endfunction

	function automatic void push_load(int a, bit lf, int s, int z, int o);
		req_t r;
		r.kind = REQ_LOAD;
		r.addr = 9'(a);
		r.leaf = lf;
		r.sym = 9'(s);
		r.zero = 9'(z);
		r.one = 9'(o);
		r.data_val = 8'($urandom_range(0, 255));
		req_backlog.insert(req_backlog.size(), r);
		pushed_count++;
		if (!gen_written[a])
			gen_wlist.insert(gen_wlist.size(), a);
		gen_written[a] = 1'b1;
		gen_inner[a] = !lf;
	endfunction

	function automatic void push_data(int v);
		req_t r;
		r.kind = REQ_DATA;
		r.addr = 9'($urandom_range(0, 511));
		r.leaf = 1'($urandom_range(0, 1));
		r.sym = 9'($urandom_range(0, 511));
		r.zero = 9'($urandom_range(0, 511));
		r.one = 9'($urandom_range(0, 511));
		r.data_val = 8'(v);
		req_backlog.insert(req_backlog.size(), r);
		pushed_count++;
	endfunction

	function automatic int written_node();
		return gen_wlist[$urandom_range(0, gen_wlist.size() - 1)];
	endfunction

	// Full binary tree rooted at the current root, random node addresses.
	function automatic void build_tree(int leaves, bit with_end);
		int addr_of [32];
		int kid0 [32];
		int kid1 [32];
		bit is_inner [32];
		bit taken [MAX_NODES];
		int open_leaves[$];
		int n, k, idx, a, c, i, s, end_node;
		n = 1;
		addr_of[0] = gen_root;
		taken[gen_root] = 1'b1;
		is_inner[0] = 1'b0;
		open_leaves.insert(open_leaves.size(), 0);
		repeat (leaves - 1) begin
			k = $urandom_range(0, open_leaves.size() - 1);
			idx = open_leaves[k];
			open_leaves.delete(k);
			is_inner[idx] = 1'b1;
			for (c = 0; c < 2; c++) begin
				do a = $urandom_range(0, 511); while (taken[a]);
				taken[a] = 1'b1;
				addr_of[n] = a;
				is_inner[n] = 1'b0;
				if (c == 0) kid0[idx] = n;
				else kid1[idx] = n;
				open_leaves.insert(open_leaves.size(), n);
				n++;
			end
		end
		end_node = with_end ? open_leaves[$urandom_range(0, open_leaves.size() - 1)] : -1;
		for (i = n - 1; i >= 0; i--) begin
			if (is_inner[i]) begin
				push_load(addr_of[i], 1'b0, $urandom_range(0, 511),
					addr_of[kid0[i]], addr_of[kid1[i]]);
			end else begin
				if (i == end_node) begin
					s = gen_eof;
				end else begin
					// often differ from the end symbol in bit 8 only
					do s = ($urandom_range(0, 3) == 0) ? (gen_eof ^ 9'h100) :
						$urandom_range(0, 511);
					while (s == gen_eof);
				end
				push_load(addr_of[i], 1'b1, s, $urandom_range(0, 511), $urandom_range(0, 511));
			end
		end
	endfunction

	function automatic void push_noise_load();
		int a;
		bit lf;
		a = $urandom_range(0, 511);
		lf = 1'($urandom_range(0, 1));
		if (!lf || a == gen_root)
			push_load(a, lf, $urandom_range(0, 511), written_node(), written_node());
		else
			push_load(a, lf, $urandom_range(0, 511), $urandom_range(0, 511),
				$urandom_range(0, 511));
	endfunction

	task automatic wait_idle();
		while (taken_count != pushed_count || decoded_due.size() != 0)
			@(negedge clk);
		repeat (DRAIN_CYCLES) @(negedge clk);
	endtask

	task automatic cfg_write(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] val);
		@(negedge clk);
		cfg_wr_en <= 1'b1;
		cfg_index <= idx;
		cfg_wdata <= val;
		@(negedge clk);
		cfg_wr_en <= 1'b0;
		if (idx == REG_ROOT_INDEX) begin
			root_reg = val;
			gen_root = val;
		end else begin
			eof_reg = val;
			gen_eof = val;
		end
	endtask

	task automatic run_phase(idx_t new_root, sym_t new_eof, int quota);
		int stop_at, pick;
		wait_idle();
		cfg_write(REG_ROOT_INDEX, new_root);
		cfg_write(REG_EOF_SYMBOL, new_eof);
		// root moves only at the next leaf
		if (gen_written[new_root] && gen_inner[new_root])
			repeat (2) push_data($urandom_range(0, 255));
		stop_at = pushed_count + quota;
		build_tree($urandom_range(2, 6), $urandom_range(0, 2) == 0);
		while (pushed_count < stop_at) begin
			pick = $urandom_range(0, 9);
			if (pick < 7) begin
				build_tree($urandom_range(2, 6), $urandom_range(0, 2) == 0);
				repeat ($urandom_range(2, 6)) push_data($urandom_range(0, 255));
			end else if (pick < 9) begin
				push_noise_load();
			end else begin
				push_data($urandom_range(0, 255));
			end
		end
	endtask

	// request driver
	always @(negedge clk) begin
		if (!arst_n) begin
			in_valid <= 1'b0;
		end else if (!in_valid || req_taken) begin
			req_taken = 1'b0;
			if (gap_left > 0) begin
				gap_left--;
				in_valid <= 1'b0;
			end else if (req_backlog.size() > 0) begin
				cur_req = req_backlog.pop_front();
				in_valid <= 1'b1;
				req_type <= cur_req.kind;
				node_addr <= cur_req.addr;
				node_leaf <= cur_req.leaf;
				node_symbol <= cur_req.sym;
				node_zero <= cur_req.zero;
				node_one <= cur_req.one;
				data_byte <= cur_req.data_val;
				if (burst_left > 1) begin
					burst_left--;
				end else if ($urandom_range(0, 5) == 0) begin
					burst_left = $urandom_range(20, 40);
					gap_left = 0;
				end else begin
					burst_left = $urandom_range(1, 8);
					gap_left = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 10);
				end
			end else begin
				in_valid <= 1'b0;
			end
		end
	end

	// result stall pattern
	always @(negedge clk) begin
		if (pat_age == 0) begin
			pat_age = 40;
			case ($urandom_range(0, 3))
				0: ready_pat = 16'hFFFF;
				1: ready_pat = 16'h8001;
				default: ready_pat = 16'($urandom_range(0, 65535)) | (16'h1 << $urandom_range(0, 15));
			endcase
		end
		pat_age--;
		out_ready <= arst_n & ready_pat[0];
		ready_pat = {ready_pat[0], ready_pat[15:1]};
	end

	// acceptance, checking and watchdog
	always @(posedge clk) begin
		if (arst_n) begin
			moved = 1'b0;
			if (in_valid && in_ready) begin
				predict_symbols(cur_req);
				req_taken = 1'b1;
				taken_count++;
				moved = 1'b1;
			end
			if (out_valid && out_ready) begin
				moved = 1'b1;
				if (decoded_due.size() == 0) begin
					$display("%0t: result with none expected: symbol %h end %b last %b",
						$time, out_symbol, out_end, out_last);
					err_count++;
				end else begin
					want = decoded_due.pop_front();
					if (out_end !== want.fin) begin
						$display("%0t: out_end expected %b actual %b", $time, want.fin, out_end);
						err_count++;
					end
					// symbol carries no meaning on an end result
					if (!want.fin && out_symbol !== want.sym) begin
						$display("%0t: out_symbol expected %h actual %h",
							$time, want.sym, out_symbol);
						err_count++;
					end
					if (out_last !== want.last) begin
						$display("%0t: out_last expected %b actual %b",
							$time, want.last, out_last);
						err_count++;
					end
				end
			end
			stall_count = moved ? 0 : stall_count + 1;
			if (stall_count >= STALL_LIMIT) begin
				$display("%0t: no progress for %0d cycles", $time, STALL_LIMIT);
				$display("tb_huffman_tree_walk_decoder: done, errors");
				$finish;
			end
		end
	end

	initial begin
		arst_n = 1'b0;
		in_valid = 1'b0;
		req_type = REQ_LOAD;
		node_addr = '0;
		node_leaf = 1'b0;
		node_symbol = '0;
		node_zero = '0;
		node_one = '0;
		data_byte = '0;
		out_ready = 1'b0;
		cfg_wr_en = 1'b0;
		cfg_index = REG_ROOT_INDEX;
		cfg_wdata = '0;
		foreach (tree_mem[i])
			tree_mem[i] = '0;
		root_reg = ROOT_RESET;
		eof_reg = EOF_RESET;
		walk_pos = ROOT_RESET;
		stream_done = 1'b0;
		gen_root = ROOT_RESET;
		gen_eof = EOF_RESET;
		pushed_count = 0;
		taken_count = 0;
		err_count = 0;
		stall_count = 0;
		burst_left = 1;
		gap_left = 0;
		pat_age = 0;
		req_taken = 1'b0;
		ready_pat = 16'hFFFF;
		repeat (9) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;

		// root is a leaf; codes: 0 -> 0, 10 -> 0x1FF, 110 -> end, 111... loops at node 5
		push_load(0, 1'b1, 5, 1, 2);
		push_load(1, 1'b1, 0, 511, 511);
		push_load(2, 1'b0, 511, 4, 5);
		push_load(4, 1'b1, 511, 0, 0);
		push_load(5, 1'b0, 0, 6, 5);
		push_load(6, 1'b1, 256, 0, 0);
		push_load(511, 1'b1, 511, 511, 511);
		push_data(8'h00);
		push_data(8'hAA);
		push_data(8'hFF);
		push_data(8'h7F);
		push_data(8'h00);
		push_load(6, 1'b1, 255, 0, 0);
		push_data(8'hC0);
		push_load(6, 1'b1, 256, 0, 0);
		push_data(8'h6F);
		push_load(2, 1'b0, 511, 4, 5);
		push_data(8'h5B);
		push_load(4, 1'b1, 511, 0, 0);

		run_phase(9'd5, 9'd511, 18);
		run_phase(9'd511, 9'd0, 18);
		run_phase(9'($urandom_range(0, 511)), 9'($urandom_range(0, 511)), 18);
		run_phase(9'd0, 9'd255, 18);
		wait_idle();

		if (err_count == 0)
			$display("tb_huffman_tree_walk_decoder: done, clean");
		else
			$display("tb_huffman_tree_walk_decoder: done, errors");
		$finish;
	end
endmodule
